@@ rtl/core/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, widths and reset values of the sampled PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int DIV_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [31:0] GAIN_P_RST = 32'd65536;
	localparam logic [31:0] GAIN_I_RST = 32'd0;
	localparam logic [31:0] GAIN_D_RST = 32'd0;
	localparam logic [15:0] PERIOD_RST = 16'd100;
	localparam logic [15:0] OUT_MIN_RST = 16'd0;
	localparam logic [15:0] OUT_MAX_RST = 16'd255;
	localparam logic USE_DERIV_RST = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_SAMPLE_PERIOD,
		REG_OUT_MIN,
		REG_OUT_MAX,
		REG_USE_DERIV
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_P,
		ST_MUL_E,
		ST_MUL_D,
		ST_MUL_IL,
		ST_MUL_IH,
		ST_ACC,
		ST_ICLAMP,
		ST_DIV,
		ST_SUM,
		ST_FIN
	} state_t;

endpackage

@@ rtl/core/pid_controller_sampled_top.sv @@
// ----------------------------------------------------------------------------
// pid_controller_sampled_top
// Sampled PID controller with integrator anti-windup and clamped drive.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high while it is worked on. An
// item whose elapsed time is below the sample period is dropped in the check
// state. An update runs its five products through one shared multiplier,
// one per cycle; with the derivative on, a serial divider forms the
// derivative term. The result sits in an output register, so the next item
// is taken while it waits.
// ----------------------------------------------------------------------------
module pid_controller_sampled_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [15:0]                   target,
	input  logic signed [15:0]                   sample,
	input  logic [31:0]                          now_ms,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [15:0]                   drive
);

	pidc_pkg::state_t state_q, state_d;

	logic [31:0]         gain_p_q, gain_i_q, gain_d_q;
	logic [15:0]         period_q;
	logic signed [15:0]  out_min_q, out_max_q;
	logic                use_deriv_q;

	logic [31:0]         last_time_q;
	logic signed [15:0]  prev_sample_q;
	logic signed [47:0]  err_sum_q;
	logic signed [15:0]  last_drive_q;
	logic                primed_q;

	logic signed [15:0]  tgt_q, smp_q;
	logic [31:0]         now_q;
	logic [31:0]         dt_q;
	logic signed [16:0]  e_q, diff_q;
	logic                d_on_q;
	logic signed [32:0]  p_q;
	logic signed [15:0]  i_q;
	logic signed [32:0]  d_q;
	logic [31:0]         dvd_q;
	logic                dneg_q;
	logic signed [79:0]  acc_q;
	logic signed [34:0]  sum_q;
	logic signed [15:0]  drive_q;
	logic                out_valid_q;

	logic                in_xfer, fin_load, skip_c;
	logic [31:0]         elapsed_c, dt_c;
	logic signed [15:0]  prev_c;
	logic signed [16:0]  e_c, diff_c;
	logic                integ_c;
	logic signed [57:0]  p_round_c, num_mag_c;
	logic signed [49:0]  s_c;
	logic signed [47:0]  s_sat_c;
	logic signed [79:0]  i_round_c;
	logic signed [15:0]  i_clamp_c, drive_c;

	logic signed [pidc_pkg::MUL_A_W-1:0] mul_a;
	logic signed [pidc_pkg::MUL_B_W-1:0] mul_b;
	logic signed [pidc_pkg::MUL_P_W-1:0] prod_q;
	logic                div_start, div_done;
	logic [pidc_pkg::DIV_W-1:0] quo;

	function automatic logic signed [15:0] clamp_lim(
		input logic signed [63:0] v,
		input logic signed [15:0] lo,
		input logic signed [15:0] hi
	);
		logic signed [63:0] lo64, hi64;
		lo64 = {{48{lo[15]}}, lo};
		hi64 = {{48{hi[15]}}, hi};
		if (v > hi64)
			clamp_lim = hi;
		else if (v < lo64)
			clamp_lim = lo;
		else
			clamp_lim = v[15:0];
	endfunction

	pidc_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	pidc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_q),
		.divisor  (dt_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign in_xfer = in_valid && !in_stall;
	assign fin_load = (state_q == pidc_pkg::ST_FIN) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign drive = drive_q;

	assign elapsed_c = now_q - last_time_q;
	assign dt_c = primed_q ? elapsed_c : {16'b0, period_q};
	assign skip_c = primed_q && (elapsed_c < {16'b0, period_q});
	assign prev_c = primed_q ? prev_sample_q : smp_q;
	assign e_c = {tgt_q[15], tgt_q} - {smp_q[15], smp_q};
	assign diff_c = {smp_q[15], smp_q} - {prev_c[15], prev_c};

	assign integ_c = !((out_max_q > 16'sd0) && (last_drive_q >= out_max_q))
		&& !((out_min_q < 16'sd0) && (last_drive_q <= out_min_q));

	assign p_round_c = prod_q + (prod_q[57] ? 58'sd65535 : 58'sd0);
	assign s_c = {{2{err_sum_q[47]}}, err_sum_q} + {prod_q[48], prod_q[48:0]};
	assign s_sat_c = (s_c[49:47] == 3'b000 || s_c[49:47] == 3'b111) ? s_c[47:0]
		: (s_c[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}});
	assign num_mag_c = prod_q[57] ? -prod_q : prod_q;
	assign i_round_c = acc_q + (acc_q[79] ? 80'sd65535 : 80'sd0);
	assign i_clamp_c = clamp_lim(i_round_c[79:16], out_min_q, out_max_q);
	assign drive_c = clamp_lim({{29{sum_q[34]}}, sum_q}, out_min_q, out_max_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pidc_pkg::ST_IDLE:   if (in_xfer) state_d = pidc_pkg::ST_CHECK;
			pidc_pkg::ST_CHECK:  state_d = skip_c ? pidc_pkg::ST_IDLE : pidc_pkg::ST_MUL_P;
			pidc_pkg::ST_MUL_P:  state_d = pidc_pkg::ST_MUL_E;
			pidc_pkg::ST_MUL_E:  state_d = pidc_pkg::ST_MUL_D;
			pidc_pkg::ST_MUL_D:  state_d = pidc_pkg::ST_MUL_IL;
			pidc_pkg::ST_MUL_IL: state_d = pidc_pkg::ST_MUL_IH;
			pidc_pkg::ST_MUL_IH: state_d = pidc_pkg::ST_ACC;
			pidc_pkg::ST_ACC:    state_d = pidc_pkg::ST_ICLAMP;
			pidc_pkg::ST_ICLAMP: state_d = d_on_q ? pidc_pkg::ST_DIV : pidc_pkg::ST_SUM;
			pidc_pkg::ST_DIV:    if (div_done) state_d = pidc_pkg::ST_SUM;
			pidc_pkg::ST_SUM:    state_d = pidc_pkg::ST_FIN;
			pidc_pkg::ST_FIN:    if (fin_load) state_d = pidc_pkg::ST_IDLE;
			default:             state_d = pidc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != pidc_pkg::ST_IDLE);
		div_start = (state_q == pidc_pkg::ST_ICLAMP) && d_on_q;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			pidc_pkg::ST_MUL_P: begin
				mul_a = {gain_p_q[31], gain_p_q};
				mul_b = {{8{e_q[16]}}, e_q};
			end
			pidc_pkg::ST_MUL_E: begin
				mul_a = {1'b0, dt_q};
				mul_b = {{8{e_q[16]}}, e_q};
			end
			pidc_pkg::ST_MUL_D: begin
				mul_a = {gain_d_q[31], gain_d_q};
				mul_b = {{8{diff_q[16]}}, diff_q};
			end
			pidc_pkg::ST_MUL_IL: begin
				mul_a = {gain_i_q[31], gain_i_q};
				mul_b = {1'b0, err_sum_q[23:0]};
			end
			pidc_pkg::ST_MUL_IH: begin
				mul_a = {gain_i_q[31], gain_i_q};
				mul_b = {err_sum_q[47], err_sum_q[47:24]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= pidc_pkg::GAIN_P_RST;
			gain_i_q <= pidc_pkg::GAIN_I_RST;
			gain_d_q <= pidc_pkg::GAIN_D_RST;
			period_q <= pidc_pkg::PERIOD_RST;
			out_min_q <= pidc_pkg::OUT_MIN_RST;
			out_max_q <= pidc_pkg::OUT_MAX_RST;
			use_deriv_q <= pidc_pkg::USE_DERIV_RST;
		end else if (cfg_we) begin
			unique case (pidc_pkg::cfg_reg_t'(cfg_index))
				pidc_pkg::REG_GAIN_P:        gain_p_q <= cfg_data;
				pidc_pkg::REG_GAIN_I:        gain_i_q <= cfg_data;
				pidc_pkg::REG_GAIN_D:        gain_d_q <= cfg_data;
				pidc_pkg::REG_SAMPLE_PERIOD: period_q <= cfg_data[15:0];
				pidc_pkg::REG_OUT_MIN:       out_min_q <= cfg_data[15:0];
				pidc_pkg::REG_OUT_MAX:       out_max_q <= cfg_data[15:0];
				pidc_pkg::REG_USE_DERIV:     use_deriv_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// controller state; the error sum is updated during the update, the rest is committed when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			prev_sample_q <= '0;
			err_sum_q <= '0;
			last_drive_q <= '0;
			primed_q <= 1'b0;
		end else begin
			if ((state_q == pidc_pkg::ST_MUL_D) && integ_c)
				err_sum_q <= s_sat_c;
			if (fin_load) begin
				last_time_q <= now_q;
				prev_sample_q <= smp_q;
				last_drive_q <= drive_c;
				primed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tgt_q <= target;
			smp_q <= sample;
			now_q <= now_ms;
		end
		if (state_q == pidc_pkg::ST_CHECK) begin
			dt_q <= dt_c;
			e_q <= e_c;
			diff_q <= diff_c;
			d_on_q <= use_deriv_q && (dt_c != '0);
		end
		if (state_q == pidc_pkg::ST_MUL_E)
			p_q <= p_round_c[48:16];
		if (state_q == pidc_pkg::ST_MUL_IL) begin
			dneg_q <= prod_q[57];
			dvd_q <= num_mag_c[47:16];
		end
		if (state_q == pidc_pkg::ST_MUL_IH)
			acc_q <= {{22{prod_q[57]}}, prod_q};
		if (state_q == pidc_pkg::ST_ACC)
			acc_q <= acc_q + {prod_q[55:0], 24'b0};
		if (state_q == pidc_pkg::ST_ICLAMP) begin
			i_q <= i_clamp_c;
			if (!d_on_q)
				d_q <= '0;
		end
		if ((state_q == pidc_pkg::ST_DIV) && div_done)
			d_q <= dneg_q ? -{1'b0, quo} : {1'b0, quo};
		if (state_q == pidc_pkg::ST_SUM)
			sum_q <= {{2{p_q[32]}}, p_q} + {{19{i_q[15]}}, i_q} - {{2{d_q[32]}}, d_q};
		if (fin_load)
			drive_q <= drive_c;
	end

endmodule

@@ rtl/core/pidc_mul.sv @@
// ----------------------------------------------------------------------------
// pidc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidc_mul (
	input  logic                                clk,
	input  logic signed [pidc_pkg::MUL_A_W-1:0] a,
	input  logic signed [pidc_pkg::MUL_B_W-1:0] b,
	output logic signed [pidc_pkg::MUL_P_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

@@ rtl/core/pidc_div.sv @@
// ----------------------------------------------------------------------------
// pidc_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module pidc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pidc_pkg::DIV_W-1:0]    dividend,
	input  logic [pidc_pkg::DIV_W-1:0]    divisor,
	output logic                          done,
	output logic [pidc_pkg::DIV_W-1:0]    quotient
);

	logic                            busy_q;
	logic [pidc_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [pidc_pkg::DIV_W-1:0]      rem_q;
	logic [pidc_pkg::DIV_W-1:0]      quo_q;
	logic [pidc_pkg::DIV_W-1:0]      dvs_q;
	logic [pidc_pkg::DIV_W:0]        shifted;
	logic [pidc_pkg::DIV_W:0]        trial;
	logic                            ge;

	assign done = busy_q && (cnt_q == '0);
	assign quotient = quo_q;
	assign shifted = {rem_q, quo_q[pidc_pkg::DIV_W-1]};
	assign ge = shifted >= {1'b0, dvs_q};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= pidc_pkg::DIV_CNT_W'(pidc_pkg::DIV_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? trial[pidc_pkg::DIV_W-1:0] : shifted[pidc_pkg::DIV_W-1:0];
			quo_q <= {quo_q[pidc_pkg::DIV_W-2:0], ge};
		end
	end

endmodule
